FILE: rtl/vtpd_pkg.sv
// ----------------------------------------------------------------------------
// Vertex transform package
// Shared command codes and the control word that travels with every item.
// ----------------------------------------------------------------------------
`default_nettype none

package vtpd_pkg;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_t;

  typedef struct packed {
    logic        valid;
    cmd_t        cmd;
    logic [1:0]  sel;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] coef;
    logic        sat;
    logic        wz;
  } ctl_t;

endpackage

`default_nettype wire

FILE: rtl/vertex_transform_perspective_divide.sv
// ----------------------------------------------------------------------------
// Vertex transform with perspective divide
// Chained 4x4 fixed-point matrix transforms followed by division by w.
// ----------------------------------------------------------------------------
// The block accepts one transfer per clock, loads and transforms alike, and
// gives one result per transform through two register stages per matrix and
// one divider stage per quotient bit. A coefficient load travels down the
// same pipeline and takes effect at its matrix stage, so every transform
// sees exactly the loads that came before it. A two-entry output buffer
// decouples the result side, and the input stalls only while that buffer is
// full.
`default_nettype none

module vertex_transform_perspective_divide #(
  parameter int COORD_WIDTH  = 32,
  parameter int FRAC_BITS    = 16,
  parameter int NUM_MATRICES = 3
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // matrix_sel, row_index, col_index, coef_value, pos_x, pos_y, pos_z, pad
  input  wire logic [135:0] s_tdata,
  // command
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // out_x, out_y, out_z
  output logic      [95:0]  m_tdata,
  // w_zero, saturated
  output logic      [1:0]   m_tuser
);
  import vtpd_pkg::*;

  localparam int CW      = COORD_WIDTH;
  localparam int IN_BITS = (CW < 32) ? CW : 32;

  logic          en;
  ctl_t          ctl [NUM_MATRICES+1];
  logic [4*CW-1:0] vec [NUM_MATRICES+1];
  ctl_t          dctl;
  logic [CW-1:0] qx, qy, qz;
  logic          push, pop;
  logic [97:0]   buf_mem [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    cnt;

  assign en       = (cnt != 2'd2);
  assign s_tready = en;

  always_comb begin
    ctl[0].valid = s_tvalid;
    ctl[0].cmd   = cmd_t'(s_tuser);
    ctl[0].sel   = s_tdata[1:0];
    ctl[0].row   = s_tdata[3:2];
    ctl[0].col   = s_tdata[5:4];
    ctl[0].coef  = s_tdata[37:6];
    ctl[0].sat   = 1'b0;
    ctl[0].wz    = 1'b0;
    vec[0][0*CW +: CW] = CW'($signed(s_tdata[38 +: IN_BITS]));
    vec[0][1*CW +: CW] = CW'($signed(s_tdata[70 +: IN_BITS]));
    vec[0][2*CW +: CW] = CW'($signed(s_tdata[102 +: IN_BITS]));
    vec[0][3*CW +: CW] = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;
  end

  for (genvar m = 0; m < NUM_MATRICES; m++) begin : g_mat
    vtpd_mstage #(.CW(CW), .F(FRAC_BITS), .M(m)) u_mstage (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl[m]),
      .vec_in  (vec[m]),
      .ctl_out (ctl[m+1]),
      .vec_out (vec[m+1])
    );
  end

  vtpd_div #(.CW(CW), .F(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl[NUM_MATRICES]),
    .vec_in  (vec[NUM_MATRICES]),
    .ctl_out (dctl),
    .qx      (qx),
    .qy      (qy),
    .qz      (qz)
  );

  assign push = en && dctl.valid && dctl.cmd == CMD_XFORM;
  assign pop  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wr_ptr] <= {dctl.sat, dctl.wz, 32'($signed(qz)), 32'($signed(qy)),
                          32'($signed(qx))};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = buf_mem[rd_ptr][95:0];
  assign m_tuser  = buf_mem[rd_ptr][97:96];

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 && !pop |=> cnt == 2'd2 && $stable(wr_ptr))
    else $error("output buffer written while full");
  a_wz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("zero w result carries nonzero data");
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result presented right after reset");

endmodule

`default_nettype wire

FILE: rtl/vtpd_mstage.sv
// ----------------------------------------------------------------------------
// Matrix stage
// Holds one 4x4 matrix and multiplies the travelling vector by it in two
// register stages: sixteen products, then row sums with shift and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_mstage #(
  parameter int CW = 32,
  parameter int F  = 16,
  parameter int M  = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire vtpd_pkg::ctl_t  ctl_in,
  input  wire logic [4*CW-1:0] vec_in,
  output vtpd_pkg::ctl_t       ctl_out,
  output logic      [4*CW-1:0] vec_out
);
  import vtpd_pkg::*;

  localparam int PW      = 2 * CW;
  localparam int SW      = 2 * CW + 2;
  localparam int IN_BITS = (CW < 32) ? CW : 32;

  logic signed [CW-1:0] coef [16];
  logic signed [CW-1:0] vin  [4];
  logic signed [PW-1:0] prod [16];
  logic signed [SW-1:0] sum  [4];
  logic signed [SW-1:0] sh   [4];
  logic signed [CW-1:0] row_res [4];
  logic [3:0]           row_sat;
  ctl_t                 ctl_a;
  ctl_t                 ctl_b;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      vin[c] = vec_in[c*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 16; k++) begin
        if (k == 0 || k == 5 || k == 10 || k == 15) begin
          coef[k] <= {{(CW-1){1'b0}}, 1'b1} << F;
        end else begin
          coef[k] <= '0;
        end
      end
    end else if (en && ctl_in.valid && ctl_in.cmd == CMD_LOAD && ctl_in.sel == 2'(M)) begin
      coef[{ctl_in.row, ctl_in.col}] <= CW'($signed(ctl_in.coef[IN_BITS-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod[r*4+c] <= PW'(coef[r*4+c]) * PW'(vin[c]);
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum[r] = SW'(prod[r*4]) + SW'(prod[r*4+1]) + SW'(prod[r*4+2]) + SW'(prod[r*4+3]);
      sh[r]  = sum[r] >>> F;
      if (sh[r][SW-1:CW-1] == '0 || sh[r][SW-1:CW-1] == '1) begin
        row_res[r] = sh[r][CW-1:0];
        row_sat[r] = 1'b0;
      end else begin
        row_res[r] = sh[r][SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        row_sat[r] = 1'b1;
      end
    end
  end

  always_comb begin
    ctl_b     = ctl_a;
    ctl_b.sat = ctl_a.sat | (|row_sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.valid   <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_a         <= ctl_in;
      ctl_out       <= ctl_b;
      for (int r = 0; r < 4; r++) begin
        vec_out[r*CW +: CW] <= row_res[r];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vtpd_div.sv
// ----------------------------------------------------------------------------
// Perspective divider
// Three pipelined restoring dividers, one quotient bit per stage, that form
// x/w, y/w and z/w with truncation toward zero and clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_div #(
  parameter int CW = 32,
  parameter int F  = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire vtpd_pkg::ctl_t  ctl_in,
  input  wire logic [4*CW-1:0] vec_in,
  output vtpd_pkg::ctl_t       ctl_out,
  output logic      [CW-1:0]   qx,
  output logic      [CW-1:0]   qy,
  output logic      [CW-1:0]   qz
);
  import vtpd_pkg::*;

  localparam int QW    = CW + F;
  localparam int STEPS = QW;

  logic [QW-1:0] nq   [STEPS+1][3];
  logic [CW-1:0] rem  [STEPS+1][3];
  logic          neg  [STEPS+1][3];
  logic [CW-1:0] dd   [STEPS+1];
  ctl_t          ctl  [STEPS+1];

  logic [QW-1:0] nq_n  [STEPS][3];
  logic [CW-1:0] rem_n [STEPS][3];
  logic [CW:0]   rs    [STEPS][3];

  logic [CW-1:0] num [3];
  logic [CW-1:0] nmag [3];
  logic [CW-1:0] den;
  logic [CW-1:0] dmag;
  logic [QW-1:0] lim;
  logic [CW-1:0] res [3];
  logic [2:0]    dsat;
  ctl_t          ctl_first;
  ctl_t          ctl_last;

  always_comb begin
    den  = vec_in[3*CW +: CW];
    dmag = den[CW-1] ? CW'(-den) : den;
    for (int l = 0; l < 3; l++) begin
      num[l]  = vec_in[l*CW +: CW];
      nmag[l] = num[l][CW-1] ? CW'(-num[l]) : num[l];
    end
  end

  always_comb begin
    for (int s = 0; s < STEPS; s++) begin
      for (int l = 0; l < 3; l++) begin
        rs[s][l] = {rem[s][l], nq[s][l][QW-1]};
        if (rs[s][l] >= {1'b0, dd[s]}) begin
          rem_n[s][l] = CW'(rs[s][l] - {1'b0, dd[s]});
          nq_n[s][l]  = {nq[s][l][QW-2:0], 1'b1};
        end else begin
          rem_n[s][l] = rs[s][l][CW-1:0];
          nq_n[s][l]  = {nq[s][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    ctl_first    = ctl_in;
    ctl_first.wz = (den == '0);
    ctl_last     = ctl[STEPS];
    ctl_last.sat = ctl[STEPS].sat | (|dsat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= STEPS; s++) begin
        ctl[s].valid <= 1'b0;
      end
    end else if (en) begin
      ctl[0]    <= ctl_first;
      dd[0]     <= dmag;
      for (int l = 0; l < 3; l++) begin
        nq[0][l]  <= {nmag[l], {F{1'b0}}};
        rem[0][l] <= '0;
        neg[0][l] <= num[l][CW-1] ^ den[CW-1];
      end
      for (int s = 0; s < STEPS; s++) begin
        ctl[s+1] <= ctl[s];
        dd[s+1]  <= dd[s];
        for (int l = 0; l < 3; l++) begin
          nq[s+1][l]  <= nq_n[s][l];
          rem[s+1][l] <= rem_n[s][l];
          neg[s+1][l] <= neg[s][l];
        end
      end
    end
  end

  always_comb begin
    lim = {{(QW-1){1'b0}}, 1'b1} << (CW - 1);
    for (int l = 0; l < 3; l++) begin
      dsat[l] = 1'b0;
      if (ctl[STEPS].wz) begin
        res[l] = '0;
      end else if (neg[STEPS][l]) begin
        if (nq[STEPS][l] > lim) begin
          res[l]  = {1'b1, {(CW-1){1'b0}}};
          dsat[l] = 1'b1;
        end else begin
          res[l] = CW'(-nq[STEPS][l][CW-1:0]);
        end
      end else begin
        if (nq[STEPS][l] > lim - 1'b1) begin
          res[l]  = {1'b0, {(CW-1){1'b1}}};
          dsat[l] = 1'b1;
        end else begin
          res[l] = nq[STEPS][l][CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out     <= ctl_last;
      qx          <= res[0];
      qy          <= res[1];
      qz          <= res[2];
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb_vertex_transform_perspective_divide.sv
// ----------------------------------------------------------------------------
// Vertex transform with perspective divide testbench
// Drives coefficient loads and vertex transforms over the input stream and
// checks every result against a fixed-point model of the three chained matrix
// stages and divide by w, or given values, under varied idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_vertex_transform_perspective_divide;
  timeunit 1ns;
  timeprecision 1ps;

  import vtpd_pkg::*;

  localparam int LATENCY    = 2 * 3 + 32 + 16 + 2;
  localparam int WATCHDOG   = 20000;
  localparam int RAND_ITEMS = 1240;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct {
    cmd_t        cmd;
    logic [1:0]  sel;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] coef;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    bit          typed;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [31:0] ez;
    logic        ewz;
    logic        esat;
  } vtx_item_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        wz;
    logic        sat;
  } vtx_result_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [95:0]  m_tdata;
  logic [1:0]   m_tuser;

  logic signed [31:0] coeffs [3][16];
  vtx_result_t        pending_results [$];
  int                 mismatches;
  int                 idle_cycles;
  int                 send_idle_pct;
  int                 recv_stall_pct;

  vertex_transform_perspective_divide u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void reset_matrices();
    for (int m = 0; m < 3; m++) begin
      for (int k = 0; k < 16; k++) begin
        coeffs[m][k] = (k % 5 == 0) ? ONE : 32'sd0;
      end
    end
  endfunction

  function automatic vtx_result_t project_vertex(logic signed [31:0] px,
                                                 logic signed [31:0] py,
                                                 logic signed [31:0] pz);
    logic signed [127:0] acc;
    logic signed [127:0] term_a;
    logic signed [127:0] term_b;
    longint              vec [4];
    longint              nxt [4];
    longint              quot;
    vtx_result_t         res;
    vec[0] = px;
    vec[1] = py;
    vec[2] = pz;
    vec[3] = 65536;
    res.sat = 1'b0;
    res.wz  = 1'b0;
    for (int m = 0; m < 3; m++) begin
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int c = 0; c < 4; c++) begin
          term_a = coeffs[m][r * 4 + c];
          term_b = vec[c];
          acc += term_a * term_b;
        end
        acc = acc >>> 16;
        if (acc > 128'sd2147483647) begin
          nxt[r] = 64'sd2147483647;
          res.sat = 1'b1;
        end else if (acc < -128'sd2147483648) begin
          nxt[r] = -64'sd2147483648;
          res.sat = 1'b1;
        end else begin
          nxt[r] = longint'(acc);
        end
      end
      vec = nxt;
    end
    if (vec[3] == 0) begin
      res.wz = 1'b1;
      res.x = '0;
      res.y = '0;
      res.z = '0;
    end else begin
      for (int r = 0; r < 3; r++) begin
        quot = (vec[r] <<< 16) / vec[3];
        if (quot > 64'sd2147483647) begin
          quot = 64'sd2147483647;
          res.sat = 1'b1;
        end else if (quot < -64'sd2147483648) begin
          quot = -64'sd2147483648;
          res.sat = 1'b1;
        end
        if (r == 0) res.x = quot[31:0];
        else if (r == 1) res.y = quot[31:0];
        else res.z = quot[31:0];
      end
    end
    return res;
  endfunction

  function automatic vtx_item_t load_item(logic [1:0] sel, logic [1:0] row,
                                          logic [1:0] col, logic [31:0] coef);
    vtx_item_t it;
    it = '{cmd: CMD_LOAD, sel: sel, row: row, col: col, coef: coef,
           px: $urandom, py: $urandom, pz: $urandom, typed: 1'b0,
           ex: '0, ey: '0, ez: '0, ewz: 1'b0, esat: 1'b0};
    return it;
  endfunction

  function automatic vtx_item_t xform_item(logic [31:0] px, logic [31:0] py,
                                           logic [31:0] pz);
    vtx_item_t it;
    it = '{cmd: CMD_XFORM, sel: 2'($urandom), row: 2'($urandom),
           col: 2'($urandom), coef: $urandom, px: px, py: py, pz: pz,
           typed: 1'b0, ex: '0, ey: '0, ez: '0, ewz: 1'b0, esat: 1'b0};
    return it;
  endfunction

  function automatic vtx_item_t typed_xform(logic [31:0] px, logic [31:0] py,
                                            logic [31:0] pz, logic [31:0] ex,
                                            logic [31:0] ey, logic [31:0] ez,
                                            logic ewz, logic esat);
    vtx_item_t it;
    it = xform_item(px, py, pz);
    it.typed = 1'b1;
    it.ex = ex;
    it.ey = ey;
    it.ez = ez;
    it.ewz = ewz;
    it.esat = esat;
    return it;
  endfunction

  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return $urandom;
    if (sel < 8) return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
    if (sel == 8) return ONE;
    return (($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000);
  endfunction

  task automatic send_item(vtx_item_t it);
    vtx_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.cmd;
    s_tdata  <= {2'b00, it.pz, it.py, it.px, it.coef, it.col, it.row, it.sel};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (it.cmd == CMD_LOAD) begin
      if (it.sel < 2'd3) coeffs[it.sel][it.row * 4 + it.col] = it.coef;
    end else begin
      res = project_vertex(it.px, it.py, it.pz);
      if (it.typed) begin
        res = '{x: it.ex, y: it.ey, z: it.ez, wz: it.ewz, sat: it.esat};
      end
      pending_results.push_back(res);
    end
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    vtx_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %h %b", m_tdata, m_tuser);
      end else begin
        exp_res = pending_results.pop_front();
        if (m_tdata !== {exp_res.z, exp_res.y, exp_res.x} ||
            m_tuser !== {exp_res.sat, exp_res.wz}) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected xyz %h %h %h wz %b sat %b, got %h %h %h wz %b sat %b",
                     exp_res.x, exp_res.y, exp_res.z, exp_res.wz, exp_res.sat,
                     m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0], m_tuser[1]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    vtx_item_t directed [$];
    vtx_item_t it;
    int        phase_len;
    mismatches     = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = CMD_LOAD;
    s_tdata  = '0;
    m_tready = 1'b0;
    reset_matrices();

    directed.push_back(typed_xform(ONE, 32'hFFFE_0000, 32'h7FFF_FFFF,
                                   ONE, 32'hFFFE_0000, 32'h7FFF_FFFF, 1'b0, 1'b0));
    directed.push_back(typed_xform(32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                   32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0));
    directed.push_back(typed_xform(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0));
    directed.push_back(load_item(2'd3, 2'd3, 2'd3, 32'h0));
    directed.push_back(typed_xform(32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 1'b0, 1'b0));
    directed.push_back(load_item(2'd2, 2'd3, 2'd3, 32'h0));
    directed.push_back(typed_xform(32'h5, 32'h5, 32'h5, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0));
    directed.push_back(load_item(2'd2, 2'd3, 2'd3, ONE));
    directed.push_back(load_item(2'd0, 2'd0, 2'd0, 32'h7FFF_FFFF));
    directed.push_back(typed_xform(32'h7FFF_FFFF, 32'h0, 32'h0,
                                   32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 1'b1));
    directed.push_back(load_item(2'd0, 2'd0, 2'd0, ONE));
    directed.push_back(load_item(2'd1, 2'd3, 2'd3, 32'h0000_0100));
    directed.push_back(xform_item(ONE, 32'h7FFF_FFFF, 32'hFFFF_8000));
    directed.push_back(load_item(2'd1, 2'd3, 2'd3, 32'hFFFF_0000));
    directed.push_back(xform_item(32'h8000_0000, ONE, 32'h7FFF_FFFF));
    directed.push_back(load_item(2'd1, 2'd3, 2'd3, ONE));
    directed.push_back(load_item(2'd0, 2'd1, 2'd3, 32'h0003_0000));
    directed.push_back(xform_item(32'h0, 32'h0, 32'h0));
    directed.push_back(load_item(2'd2, 2'd0, 2'd3, 32'h8000_0000));
    directed.push_back(xform_item(32'h0002_0000, 32'h0, 32'h0));
    directed.push_back(load_item(2'd0, 2'd1, 2'd3, 32'h0));
    directed.push_back(load_item(2'd2, 2'd0, 2'd3, 32'h0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < directed.size(); i++) send_item(directed[i]);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);

    phase_len = RAND_ITEMS / 4;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 18 : 0;
      recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 18 : 0;
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 99) < 25) begin
          it = load_item(2'($urandom), 2'($urandom), 2'($urandom), pick_value());
          if ($urandom_range(0, 19) == 0) it.coef = 32'h0;
          if ($urandom_range(0, 9) == 0) it.coef = ONE;
        end else begin
          it = xform_item(pick_value(), pick_value(), pick_value());
        end
        send_item(it);
        if ($urandom_range(0, 299) == 0) begin
          for (int k = 0; k < 48; k++) begin
            send_item(load_item(2'(k / 16), 2'((k % 16) / 4), 2'(k % 4),
                                ((k % 16) % 5 == 0) ? ONE : 32'h0));
          end
        end
      end
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
